// ===== src/plcm_pkg.sv =====
// Shared types, widths and codes for the piecewise linear color map.
package plcm_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = 4;
	localparam int POS_W      = 17;
	localparam int RGBA_W     = 32;
	localparam int SAMPLE_W   = 16;
	localparam int CNT_W      = 5;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int FRAC_W     = 16;
	localparam int Q_W        = FRAC_W + 1;
	localparam int DIV_STAGES = Q_W;
	localparam int CH_W       = 8;
	localparam int CHANNELS   = RGBA_W / CH_W;
	localparam int ONE_Q      = 1 << FRAC_W;
	localparam int IN_BITS    = IDX_W + POS_W + RGBA_W + SAMPLE_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd2;

	localparam logic [RGBA_W-1:0] RGBA_EMPTY  = 32'h0000_0000;
	localparam logic [RGBA_W-1:0] RGBA_NO_SEG = 32'h0000_00FF;

	typedef struct packed {
		logic                req_type;
		logic [IDX_W-1:0]    point_index;
		logic [POS_W-1:0]    point_position;
		logic [RGBA_W-1:0]   point_rgba;
		logic [SAMPLE_W-1:0] sample;
	} req_t;

	typedef struct packed {
		logic              req_type;
		logic [IDX_W-1:0]  point_index;
		logic [POS_W-1:0]  point_position;
		logic [RGBA_W-1:0] point_rgba;
		logic [POS_W-1:0]  n;
	} norm_t;

endpackage

// ===== src/plcm_div.sv =====
// Pipelined restoring divider: q = (a << FRAC_W) / d for a < 2d, one quotient bit per stage.
module plcm_div
	import plcm_pkg::*;
(
	input  logic           clk,
	input  logic           en,
	input  logic [Q_W-1:0] a,
	input  logic [Q_W-1:0] d,
	output logic [Q_W-1:0] q
);

	logic [Q_W-1:0]        rem_s [DIV_STAGES];
	logic [Q_W-1:0]        dv_s  [DIV_STAGES];
	logic [Q_W-1:0]        quo_s [DIV_STAGES];
	logic [Q_W-1:0]        rem_nx [DIV_STAGES];
	logic [Q_W-1:0]        quo_nx [DIV_STAGES];
	logic [Q_W:0]          sh [DIV_STAGES];
	logic [Q_W:0]          dd [DIV_STAGES];
	logic [DIV_STAGES-1:0] ge;

	always_comb begin
		sh[0] = {1'b0, a};
		dd[0] = {1'b0, d};
		for (int k = 1; k < DIV_STAGES; k++) begin
			sh[k] = {rem_s[k-1], 1'b0};
			dd[k] = {1'b0, dv_s[k-1]};
		end
		for (int k = 0; k < DIV_STAGES; k++) begin
			ge[k] = sh[k] >= dd[k];
			rem_nx[k] = ge[k] ? Q_W'(sh[k] - dd[k]) : sh[k][Q_W-1:0];
		end
		quo_nx[0] = {ge[0], {(Q_W-1){1'b0}}};
		for (int k = 1; k < DIV_STAGES; k++) begin
			quo_nx[k] = quo_s[k-1] | (Q_W'(ge[k]) << (Q_W - 1 - k));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= d;
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_s[k] <= rem_nx[k];
				quo_s[k] <= quo_nx[k];
			end
			for (int k = 1; k < DIV_STAGES; k++) begin
				dv_s[k] <= dv_s[k-1];
			end
		end
	end

	assign q = quo_s[DIV_STAGES-1];

endmodule

// ===== src/plcm_norm.sv =====
// Sample normalization: (sample - min) * 2^16 / (max - min), clamped to the position range.
module plcm_norm
	import plcm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  req_t                in_req,
	input  logic [CFG_W-1:0]    range_min,
	input  logic [CFG_W-1:0]    range_max,
	output logic                out_valid,
	output norm_t               out_item
);

	typedef struct packed {
		logic              req_type;
		logic [IDX_W-1:0]  point_index;
		logic [POS_W-1:0]  point_position;
		logic [RGBA_W-1:0] point_rgba;
		logic              neg;
		logic              zero;
		logic              ovf;
	} side_t;

	logic                  valid_s1, valid_s2, valid_s3;
	req_t                  req_s1;
	logic [CFG_W:0]        diff_s1, den_s1;
	side_t                 side_s2;
	logic [Q_W-1:0]        a_s2, d_s2;
	side_t                 div_side_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] div_valid_s;
	norm_t                 item_s3;

	logic [CFG_W-1:0] abs_a, abs_d;
	logic             zero_c, ovf_c;
	logic [Q_W-1:0]   q;
	side_t            side_last;
	logic [POS_W-1:0] n_c;

	always_comb begin
		abs_a  = diff_s1[CFG_W] ? CFG_W'(-diff_s1) : diff_s1[CFG_W-1:0];
		abs_d  = den_s1[CFG_W] ? CFG_W'(-den_s1) : den_s1[CFG_W-1:0];
		zero_c = den_s1 == '0;
		ovf_c  = {1'b0, abs_a} >= {abs_d, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1  <= in_req;
			diff_s1 <= {1'b0, in_req.sample} - {1'b0, range_min};
			den_s1  <= {1'b0, range_max} - {1'b0, range_min};
			side_s2 <= '{req_type: req_s1.req_type, point_index: req_s1.point_index,
				point_position: req_s1.point_position, point_rgba: req_s1.point_rgba,
				neg: diff_s1[CFG_W] ^ den_s1[CFG_W], zero: zero_c, ovf: ovf_c};
			// keep the divider inside its a < 2d range when the result is overridden
			a_s2    <= (zero_c || ovf_c) ? '0 : Q_W'(abs_a);
			d_s2    <= (zero_c || ovf_c) ? Q_W'(1) : Q_W'(abs_d);
			div_side_s[0] <= side_s2;
			for (int k = 1; k < DIV_STAGES; k++) begin
				div_side_s[k] <= div_side_s[k-1];
			end
			item_s3 <= '{req_type: side_last.req_type, point_index: side_last.point_index,
				point_position: side_last.point_position, point_rgba: side_last.point_rgba,
				n: n_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			div_valid_s <= '0;
			valid_s3    <= 1'b0;
		end else if (en) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			div_valid_s <= {div_valid_s[DIV_STAGES-2:0], valid_s2};
			valid_s3    <= div_valid_s[DIV_STAGES-1];
		end
	end

	plcm_div u_div (
		.clk (clk),
		.en  (en),
		.a   (a_s2),
		.d   (d_s2),
		.q   (q)
	);

	// A zero range or a negative value clamps to zero, overflow to all ones; both keep every compare intact.
	always_comb begin
		side_last = div_side_s[DIV_STAGES-1];
		priority if (side_last.zero || side_last.neg) begin
			n_c = '0;
		end else if (side_last.ovf) begin
			n_c = '1;
		end else begin
			n_c = q;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

// ===== src/plcm_seg.sv =====
// Control point table, segment search, interpolation divider and channel blend.
module plcm_seg
	import plcm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  norm_t             in_item,
	input  logic [CNT_W-1:0]  point_count,
	output logic              out_valid,
	output logic [RGBA_W-1:0] out_rgba
);

	typedef enum logic [1:0] {KIND_CONST, KIND_ENTRY, KIND_SEG} kind_t;

	typedef struct packed {
		logic              fixed;
		logic [RGBA_W-1:0] c_lo;
		logic [RGBA_W-1:0] c_hi;
	} side_t;

	logic [POS_W-1:0]  pos_q [MAX_POINTS];
	logic [RGBA_W-1:0] col_q [MAX_POINTS];

	logic [CNT_W-1:0]      cnt;
	logic [MAX_POINTS-1:0] ge, le, hit, first, last_sel;
	logic                  below, above;
	kind_t                 kind_c;
	logic [MAX_POINTS-1:0] sel_c;
	logic [RGBA_W-1:0]     const_c;

	logic                  valid_s1;
	kind_t                 kind_s1;
	logic [MAX_POINTS-1:0] sel_s1;
	logic [RGBA_W-1:0]     const_s1;
	logic [POS_W-1:0]      n_s1;

	logic [POS_W-1:0]  p_lo, p_hi;
	logic [RGBA_W-1:0] c_lo, c_hi;
	side_t             side_c;

	logic             valid_s2;
	side_t            side_s2;
	logic [Q_W-1:0]   a_s2, d_s2;

	side_t                 div_side_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] div_valid_s;
	logic [Q_W-1:0]        q;
	side_t                 side_last;

	logic                  valid_s3;
	side_t                 side_s3;
	logic [CH_W+Q_W-1:0]   pa_s3 [CHANNELS];
	logic [CH_W+Q_W-1:0]   pb_s3 [CHANNELS];
	logic [Q_W-1:0]        w_lo;

	logic              valid_s4;
	logic [RGBA_W-1:0] rgba_s4;
	logic [RGBA_W-1:0] blend_c;
	logic [CH_W+Q_W:0] sum_c;

	// Write a control point as the write item leaves the input stage.
	always_ff @(posedge clk) begin
		if (en && in_valid && in_item.req_type == REQ_WRITE) begin
			for (int i = 0; i < MAX_POINTS; i++) begin
				if ({1'b0, in_item.point_index} == (IDX_W+1)'(i)) begin
					pos_q[i] <= in_item.point_position;
					col_q[i] <= in_item.point_rgba;
				end
			end
		end
	end

	always_comb begin
		cnt = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;
		for (int i = 0; i < MAX_POINTS; i++) begin
			ge[i]       = in_item.n >= pos_q[i];
			le[i]       = in_item.n <= pos_q[i];
			last_sel[i] = cnt == CNT_W'(i + 1);
		end
		hit = '0;
		for (int i = 0; i < MAX_POINTS - 1; i++) begin
			hit[i] = ge[i] & le[i+1] & (CNT_W'(i + 1) < cnt);
		end
		first = hit & (~hit + MAX_POINTS'(1));
		below = le[0];
		above = |(last_sel & ge);
		kind_c  = KIND_CONST;
		sel_c   = '0;
		const_c = RGBA_EMPTY;
		priority if (cnt == '0) begin
			kind_c = KIND_CONST;
		end else if (cnt == CNT_W'(1) || below) begin
			kind_c = KIND_ENTRY;
			sel_c  = MAX_POINTS'(1);
		end else if (above) begin
			kind_c = KIND_ENTRY;
			sel_c  = last_sel;
		end else if (|hit) begin
			kind_c = KIND_SEG;
			sel_c  = first;
		end else begin
			kind_c  = KIND_CONST;
			const_c = RGBA_NO_SEG;
		end
	end

	always_comb begin
		p_lo = '0;
		p_hi = '0;
		c_lo = '0;
		c_hi = '0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			p_lo = p_lo | ({POS_W{sel_s1[i]}} & pos_q[i]);
			c_lo = c_lo | ({RGBA_W{sel_s1[i]}} & col_q[i]);
		end
		for (int i = 0; i < MAX_POINTS - 1; i++) begin
			p_hi = p_hi | ({POS_W{sel_s1[i]}} & pos_q[i+1]);
			c_hi = c_hi | ({RGBA_W{sel_s1[i]}} & col_q[i+1]);
		end
		side_c.c_hi = c_hi;
		unique case (kind_s1)
			KIND_SEG: begin
				side_c.fixed = p_hi == p_lo;
				side_c.c_lo  = c_lo;
			end
			KIND_ENTRY: begin
				side_c.fixed = 1'b1;
				side_c.c_lo  = c_lo;
			end
			default: begin
				side_c.fixed = 1'b1;
				side_c.c_lo  = const_s1;
			end
		endcase
	end

	always_comb begin
		w_lo = Q_W'(ONE_Q) - q;
		for (int c = 0; c < CHANNELS; c++) begin
			sum_c = {1'b0, pa_s3[c]} + {1'b0, pb_s3[c]};
			blend_c[c*CH_W +: CH_W] = sum_c[FRAC_W +: CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1  <= kind_c;
			sel_s1   <= sel_c;
			const_s1 <= const_c;
			n_s1     <= in_item.n;
			side_s2  <= side_c;
			a_s2     <= side_c.fixed ? '0 : Q_W'(n_s1 - p_lo);
			d_s2     <= side_c.fixed ? Q_W'(1) : Q_W'(p_hi - p_lo);
			div_side_s[0] <= side_s2;
			for (int k = 1; k < DIV_STAGES; k++) begin
				div_side_s[k] <= div_side_s[k-1];
			end
			side_s3 <= side_last;
			for (int c = 0; c < CHANNELS; c++) begin
				pa_s3[c] <= side_last.c_lo[c*CH_W +: CH_W] * w_lo;
				pb_s3[c] <= side_last.c_hi[c*CH_W +: CH_W] * q;
			end
			rgba_s4 <= side_s3.fixed ? side_s3.c_lo : blend_c;
		end
	end

	assign side_last = div_side_s[DIV_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			div_valid_s <= '0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
		end else if (en) begin
			valid_s1    <= in_valid && in_item.req_type == REQ_LOOKUP;
			valid_s2    <= valid_s1;
			div_valid_s <= {div_valid_s[DIV_STAGES-2:0], valid_s2};
			valid_s3    <= div_valid_s[DIV_STAGES-1];
			valid_s4    <= valid_s3;
		end
	end

	plcm_div u_div (
		.clk (clk),
		.en  (en),
		.a   (a_s2),
		.d   (d_s2),
		.q   (q)
	);

	assign out_valid = valid_s4;
	assign out_rgba  = rgba_s4;

`ifndef SYNTHESIS
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(sel_s1))
		else $error("segment select is not one-hot");
	a_seg_has_sel: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && kind_s1 == KIND_SEG |-> sel_s1 != '0)
		else $error("segment lookup without a selected segment");
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !side_s2.fixed |-> a_s2 <= d_s2 && d_s2 != '0)
		else $error("interpolation divider operands out of range");
`endif

endmodule

// ===== src/piecewise_linear_color_map_top.sv =====
// Top level of the piecewise linear RGBA transfer function.
//
// Usage:
//   Slave stream (s_*) carries requests. tuser selects the kind: write a control
//   point into a table slot, or look up a sample. A write returns nothing; a
//   lookup returns exactly one RGBA transaction on the master stream (m_*).
//   Configuration (range_min, range_max, point_count) is written on the cfg_*
//   port while the block is idle. Control points go in ascending position order.
// Pipeline and throughput:
//   A lookup passes normalization (two setup stages, a 17-stage divider, a clamp
//   stage), then segment search, the 17-stage interpolation divider and the blend.
//   One transaction enters every cycle unless backpressure holds the pipeline;
//   the two dividers, one quotient bit per stage, set the pipeline depth.
// Reset:
//   arst_n clears all valid bits and the registers to range 0..300, no points.
//   Table contents are undefined until written.
// Backpressure:
//   When m_tready is low with a result pending, the whole pipeline holds and
//   s_tready drops; nothing is dropped or repeated.
module piecewise_linear_color_map_top
	import plcm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // point_index, point_position, point_rgba, sample
	input  logic                  s_tuser,  // req_type
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [RGBA_W-1:0]     m_tdata   // red, green, blue, alpha
);

	logic [CFG_W-1:0] range_min_q;
	logic [CFG_W-1:0] range_max_q;
	logic [CNT_W-1:0] point_count_q;

	logic              en;
	req_t              req;
	logic              norm_valid;
	norm_t             norm_item;
	logic [RGBA_W-1:0] rgba;

	// Advance every stage together unless a result waits on a stalled receiver.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Unpack the request; fields sit lowest first in tdata.
	assign req = '{req_type: s_tuser,
		point_index:    s_tdata[IDX_W-1:0],
		point_position: s_tdata[IDX_W +: POS_W],
		point_rgba:     s_tdata[IDX_W+POS_W +: RGBA_W],
		sample:         s_tdata[IDX_W+POS_W+RGBA_W +: SAMPLE_W]};

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q   <= CFG_W'(0);
			range_max_q   <= CFG_W'(300);
			point_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RANGE_MIN:   range_min_q   <= cfg_wdata;
				CFG_RANGE_MAX:   range_max_q   <= cfg_wdata;
				CFG_POINT_COUNT: point_count_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	plcm_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_req    (req),
		.range_min (range_min_q),
		.range_max (range_max_q),
		.out_valid (norm_valid),
		.out_item  (norm_item)
	);

	plcm_seg u_seg (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (norm_valid),
		.in_item     (norm_item),
		.point_count (point_count_q),
		.out_valid   (m_tvalid),
		.out_rgba    (rgba)
	);

	// Red goes out in the lowest byte.
	assign m_tdata = {rgba[CH_W-1:0], rgba[2*CH_W-1:CH_W], rgba[3*CH_W-1:2*CH_W],
		rgba[4*CH_W-1:3*CH_W]};

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for piecewise_linear_color_map_top.
module tb;
	import plcm_pkg::*;

	// register index that maps to nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;   // point_index, point_position, point_rgba, sample
	logic                  s_tuser = 1'b0; // req_type
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [RGBA_W-1:0]     m_tdata;        // red, green, blue, alpha

	piecewise_linear_color_map_top DUT (.*);

	// Shadow copy of the block state, updated at each accepted transaction.
	logic [15:0]        sh_min = 16'd0;
	logic [15:0]        sh_max = 16'd300;
	logic [4:0]         sh_count = 5'd0;
	logic [POS_W-1:0]   sh_pos [MAX_POINTS];
	logic [RGBA_W-1:0]  sh_col [MAX_POINTS];

	logic [RGBA_W-1:0]  pending_colors [$];
	int                 errors = 0;
	bit                 quiet = 1'b0;   // no idling on either side while set
	int                 stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("piecewise_linear_color_map_top test failed");
		$finish;
	end

	task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
		$display("%0t: %s mismatch: got %02h expected %02h", $realtime, field, got, want);
		errors++;
	endtask

	// Interpolate one RGBA word between two colors at fraction t (Q1.16).
	function automatic logic [RGBA_W-1:0] mix_colors(logic [RGBA_W-1:0] c1,
			logic [RGBA_W-1:0] c2, longint t);
		logic [RGBA_W-1:0] res;
		longint a, b;
		res = '0;
		for (int sh = 0; sh < 32; sh += 8) begin
			a = (c1 >> sh) & 255;
			b = (c2 >> sh) & 255;
			res |= RGBA_W'(((a * (65536 - t) + b * t) >> 16) & 255) << sh;
		end
		return res;
	endfunction

	// Color the block should return for one sample under the shadow state.
	function automatic logic [RGBA_W-1:0] color_of(logic [15:0] s);
		longint n, p1, p2;
		int cnt;
		n = 0;
		cnt = (sh_count > MAX_POINTS) ? MAX_POINTS : int'(sh_count);
		if (sh_max != sh_min)
			n = ((longint'(s) - longint'(sh_min)) * 65536) / (longint'(sh_max) - longint'(sh_min));
		if (cnt == 0) return RGBA_EMPTY;
		if (cnt == 1) return sh_col[0];
		if (n <= longint'(sh_pos[0])) return sh_col[0];
		if (n >= longint'(sh_pos[cnt-1])) return sh_col[cnt-1];
		for (int i = 0; i + 1 < cnt; i++) begin
			p1 = sh_pos[i];
			p2 = sh_pos[i+1];
			if (n >= p1 && n <= p2) begin
				if (p2 == p1) return sh_col[i];
				return mix_colors(sh_col[i], sh_col[i+1], ((n - p1) * 65536) / (p2 - p1));
			end
		end
		return RGBA_NO_SEG;
	endfunction

	// Receiver: random stalls, compare each result transaction with the oldest prediction.
	always @(posedge clk) begin
		logic [RGBA_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_colors.size() == 0) begin
				$display("%0t: unexpected result %08h", $realtime, m_tdata);
				errors++;
			end else begin
				want = pending_colors.pop_front();
				if (m_tdata[7:0]   !== want[31:24]) report_mismatch("red",   m_tdata[7:0],   want[31:24]);
				if (m_tdata[15:8]  !== want[23:16]) report_mismatch("green", m_tdata[15:8],  want[23:16]);
				if (m_tdata[23:16] !== want[15:8])  report_mismatch("blue",  m_tdata[23:16], want[15:8]);
				if (m_tdata[31:24] !== want[7:0])   report_mismatch("alpha", m_tdata[31:24], want[7:0]);
			end
		end
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Send one transaction; predict at acceptance. Leaves s_tvalid high.
	task automatic send_item(logic kind, logic [3:0] idx, logic [POS_W-1:0] pos,
			logic [RGBA_W-1:0] rgba, logic [15:0] s);
		int gap;
		gap = quiet ? 0 : (($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3)));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= IN_TDATA_W'({s, rgba, pos, idx});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind == REQ_WRITE) begin
			sh_pos[idx] = pos;
			sh_col[idx] = rgba;
		end else begin
			pending_colors = {pending_colors, color_of(s)};
		end
	endtask

	task automatic write_point(int idx, logic [POS_W-1:0] pos, logic [RGBA_W-1:0] rgba);
		send_item(REQ_WRITE, 4'(idx), pos, rgba, 16'($urandom));
	endtask

	task automatic lookup(logic [15:0] s);
		send_item(REQ_LOOKUP, 4'($urandom), POS_W'($urandom), $urandom, s);
	endtask

	// Hold off until every expected result is back, then let the pipeline empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Register write; only called while drained.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_RANGE_MIN:   sh_min = val;
			CFG_RANGE_MAX:   sh_max = val;
			CFG_POINT_COUNT: sh_count = val[4:0];
			default: ;
		endcase
	endtask

	// Fill all slots with sorted random positions, some repeated for zero-width segments.
	task automatic load_sorted_table();
		int p [MAX_POINTS];
		for (int i = 0; i < MAX_POINTS; i++) p[i] = $urandom_range(0, 65536);
		p.sort();
		for (int i = 1; i < MAX_POINTS; i++)
			if ($urandom_range(0, 7) == 0) p[i] = p[i-1];
		for (int i = 0; i < MAX_POINTS; i++) write_point(i, POS_W'(p[i]), $urandom);
	endtask

	task automatic test_reset_state();
		// empty table on reset range, then the full sample span
		lookup(16'd0);
		lookup(16'd150);
		lookup(16'hFFFF);
	endtask

	task automatic test_single_point();
		write_point(0, 17'd65536, 32'hFFFF_FFFF);
		drain();
		write_reg(CFG_POINT_COUNT, 16'd1);
		lookup(16'd0);
		lookup(16'hFFFF);
	endtask

	task automatic test_segments();
		// hand-built table: a ramp, a zero-width step, and endpoints at 0 and 1.0
		write_point(1, 17'd16384, 32'h00FF_8000);
		write_point(2, 17'd16384, 32'h8000_FF40);
		write_point(3, 17'd65536, 32'hFF00_00FF);
		write_point(0, 17'd0,     32'h0000_0000);
		drain();
		write_reg(CFG_RANGE_MIN, 16'd100);
		write_reg(CFG_RANGE_MAX, 16'd200);
		write_reg(CFG_POINT_COUNT, 16'd4);
		lookup(16'd0);      // below first
		lookup(16'd100);
		lookup(16'd110);
		lookup(16'd125);    // lands on the repeated position
		lookup(16'd160);
		lookup(16'd200);
		lookup(16'hFFFF);   // above last
	endtask

	task automatic test_range_extremes();
		drain();
		write_reg(CFG_RANGE_MAX, 16'd100);   // equal ends: normalized value is zero
		lookup(16'd7);
		drain();
		write_reg(CFG_RANGE_MIN, 16'hFFFF);  // inverted range gives negative slopes
		write_reg(CFG_RANGE_MAX, 16'd0);
		lookup(16'd0);
		lookup(16'h8000);
		drain();
		write_reg(CFG_UNUSED, 16'hFFFF);     // unused index, must have no effect
		write_reg(CFG_RANGE_MIN, 16'd0);
		write_reg(CFG_RANGE_MAX, 16'hFFFF);
		lookup(16'h4000);
	endtask

	task automatic test_out_of_order();
		// descending interior points make the first and third segments overlap; the first one wins
		write_point(0, 17'd0,     32'h1122_3344);
		write_point(1, 17'd50000, 32'h5566_7788);
		write_point(2, 17'd10000, 32'h99AA_BBCC);
		write_point(3, 17'd60000, 32'hDDEE_FF00);
		drain();
		write_reg(CFG_POINT_COUNT, 16'd4);
		lookup(16'h7000);
		lookup(16'hC000);
	endtask

	task automatic test_random();
		int cnt;
		for (int ph = 0; ph < 6; ph++) begin
			quiet = (ph == 2);
			if (ph == 4) begin
				for (int i = 0; i < MAX_POINTS; i++)
					write_point(i, POS_W'($urandom_range(0, 65536)), $urandom);
			end else begin
				load_sorted_table();
			end
			drain();
			case (ph)
				0: begin write_reg(CFG_RANGE_MIN, 16'd0); write_reg(CFG_RANGE_MAX, 16'hFFFF); end
				1: begin write_reg(CFG_RANGE_MIN, 16'hFFFF); write_reg(CFG_RANGE_MAX, 16'd0); end
				default: begin
					write_reg(CFG_RANGE_MIN, 16'($urandom));
					write_reg(CFG_RANGE_MAX, 16'($urandom));
				end
			endcase
			cnt = (ph == 1) ? 31 : (ph == 5) ? MAX_POINTS : $urandom_range(2, 20);
			write_reg(CFG_POINT_COUNT, 16'(cnt));
			for (int k = 0; k < 45; k++) begin
				// writes only to slots above the active count, never read back
				if (cnt < MAX_POINTS && $urandom_range(0, 9) == 0)
					write_point($urandom_range(cnt, MAX_POINTS - 1), POS_W'($urandom), $urandom);
				else if ($urandom_range(0, 3) == 0)
					lookup(16'($urandom));
				else if (sh_min <= sh_max)
					lookup(16'($urandom_range(sh_min, sh_max)));
				else
					lookup(16'($urandom_range(sh_max, sh_min)));
			end
			drain();
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_state();
		test_single_point();
		test_segments();
		test_range_extremes();
		test_out_of_order();
		test_random();
		drain();
		if (errors == 0)
			$display("piecewise_linear_color_map_top test passed");
		else
			$display("piecewise_linear_color_map_top test failed");
		$finish;
	end

endmodule
